FILE: src/psf_splat_accumulator_unit_assert.svh
// Assertion macros for the PSF splat accumulator.
`ifndef PSF_SPLAT_ACCUMULATOR_UNIT_ASSERT_SVH
`define PSF_SPLAT_ACCUMULATOR_UNIT_ASSERT_SVH
`ifndef SYNTHESIS
`define PSU_ASSERT(lbl, prop) lbl: assert property (@(posedge clk) disable iff (!rst_n) \
  prop) else $error("psu assertion failed");
`define PSU_NEVER(lbl, cond) lbl: assert property (@(posedge clk) disable iff (!rst_n) \
  !(cond)) else $error("psu forbidden condition");
`else
`define PSU_ASSERT(lbl, prop)
`define PSU_NEVER(lbl, cond)
`endif
`endif

FILE: src/psu_pkg.sv
// Shared types and constants of the PSF splat accumulator.
package psu_pkg;

  localparam int CHANNELS_DEF        = 4;
  localparam int PSF_LATERAL_MAX_DEF = 32;
  localparam int PSF_AXIAL_MAX_DEF   = 64;
  localparam int FRAME_L_DEF         = 256;
  localparam int FRAME_M_DEF         = 256;

  // Rounded lateral position width and its signed walk width
  localparam int XW = 13;
  localparam int SW = XW + 1;
  // First (top) shift step of the modulo unit
  localparam int MOD_TOP = XW - 1;

  localparam int CFG_IW = 3;
  localparam int CFG_DW = 20;

  typedef enum logic [1:0] {
    OP_LOAD  = 2'd0,
    OP_SPLAT = 2'd1,
    OP_READ  = 2'd2,
    OP_NONE  = 2'd3
  } op_t;

  typedef enum logic [CFG_IW-1:0] {
    CFG_BOX_L       = 3'd0,
    CFG_BOX_M       = 3'd1,
    CFG_PSF_LATERAL = 3'd2,
    CFG_PSF_AXIAL   = 3'd3,
    CFG_FOCUS       = 3'd4,
    CFG_AXIAL_LEN   = 3'd5,
    CFG_PBC_MASK    = 3'd6
  } cfg_idx_t;

  typedef enum logic [3:0] {
    ST_CLEAR, ST_IDLE, ST_LOAD_A, ST_LOAD_B, ST_SETUP, ST_MOD,
    ST_WALK, ST_DRAIN, ST_RD_ISSUE, ST_RD_WAIT, ST_RD_DONE
  } state_t;

  typedef struct packed {
    op_t         operation;
    logic [1:0]  channel;
    logic [19:0] pos_l;
    logic [19:0] pos_m;
    logic [19:0] pos_n;
    logic [7:0]  row_index;
    logic [7:0]  column_index;
    logic [5:0]  depth_index;
    logic [15:0] psf_value;
  } in_item_t;

  typedef struct packed {
    logic [31:0] pixel_value;
    logic        outside_box;
  } out_item_t;

endpackage

FILE: src/psu_ram.sv
// Simple dual-port RAM with one write port and one registered read port.
module psu_ram #(
  parameter int W     = 16,
  parameter int DEPTH = 1024,
  localparam int AW   = ($clog2(DEPTH) > 0) ? $clog2(DEPTH) : 1
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [W-1:0]  wdata,
  input  logic [AW-1:0] raddr,
  output logic [W-1:0]  rdata
);

  logic [W-1:0] mem [DEPTH];

  // Write one word
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Register the read word
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

FILE: src/psf_splat_accumulator_unit.sv
// Top level of the PSF splat accumulator: sequencer, address walk and pixel update.
//
// Usage: items enter on in_valid/in_stall/in_data; an item is taken when
// in_valid is high and in_stall is low. Only read items give a result beat on
// out_valid/out_stall/out_data. The user must write registers through cfg_we,
// cfg_index and cfg_wdata only while the block is idle; it is not enforced.
// Steps per item: a load passes ST_LOAD_A and ST_LOAD_B, a read ST_RD_ISSUE,
// ST_RD_WAIT and ST_RD_DONE up to the output register. A splat passes
// ST_SETUP, ST_MOD per wrapped lateral axis in the shared add/compare/subtract
// unit, ST_WALK over every window pixel, (2P-1)^2, and ST_DRAIN. The pixel
// walk does one read-modify-write of the image RAM a cycle, with a forward
// path for back-to-back hits on one pixel.
// Reset: a clearing pass zeroes both memories, one entry a cycle, over
// max(CHANNELS*PSF_LATERAL_MAX^2*PSF_AXIAL_MAX, CHANNELS*FRAME_L*FRAME_M)
// entries (262144 at defaults); in_stall stays high meanwhile.
// Stall: the result register holds while out_stall is high; the block takes
// the next item meanwhile and holds a new read result until the slot frees.
`include "psf_splat_accumulator_unit_assert.svh"
module psf_splat_accumulator_unit #(
  parameter int CHANNELS        = psu_pkg::CHANNELS_DEF,
  parameter int PSF_LATERAL_MAX = psu_pkg::PSF_LATERAL_MAX_DEF,
  parameter int PSF_AXIAL_MAX   = psu_pkg::PSF_AXIAL_MAX_DEF,
  parameter int FRAME_L         = psu_pkg::FRAME_L_DEF,
  parameter int FRAME_M         = psu_pkg::FRAME_M_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  psu_pkg::in_item_t             in_data,
  output logic                          out_valid,
  input  logic                          out_stall,
  output psu_pkg::out_item_t            out_data,
  input  logic                          cfg_we,
  input  logic [psu_pkg::CFG_IW-1:0]    cfg_index,
  input  logic [psu_pkg::CFG_DW-1:0]    cfg_wdata
);
  import psu_pkg::*;

  localparam int PSF_ROW   = PSF_LATERAL_MAX * PSF_AXIAL_MAX;
  localparam int PSF_CH    = PSF_LATERAL_MAX * PSF_ROW;
  localparam int PSF_DEPTH = CHANNELS * PSF_CH;
  localparam int IMG_CH    = FRAME_L * FRAME_M;
  localparam int IMG_DEPTH = CHANNELS * IMG_CH;
  localparam int CLR_DEPTH = (PSF_DEPTH > IMG_DEPTH) ? PSF_DEPTH : IMG_DEPTH;
  localparam int PAW  = ($clog2(PSF_DEPTH) > 0) ? $clog2(PSF_DEPTH) : 1;
  localparam int IAW  = ($clog2(IMG_DEPTH) > 0) ? $clog2(IMG_DEPTH) : 1;
  localparam int CLRW = $clog2(CLR_DEPTH) + 1;
  localparam int LW   = ($clog2(PSF_LATERAL_MAX) > 0) ? $clog2(PSF_LATERAL_MAX) : 1;
  localparam int KW   = ($clog2(PSF_AXIAL_MAX) > 0) ? $clog2(PSF_AXIAL_MAX) : 1;
  localparam int FLW  = $clog2(FRAME_L + 1);
  localparam int FMW  = $clog2(FRAME_M + 1);

  // Configuration registers
  logic [8:0]  box_l_r, box_m_r;
  logic [5:0]  psf_lateral_r;
  logic [6:0]  psf_axial_r;
  logic [19:0] focus_r, axial_len_r;
  logic [2:0]  pbc_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      box_l_r       <= 9'd256;
      box_m_r       <= 9'd256;
      psf_lateral_r <= 6'd32;
      psf_axial_r   <= 7'd64;
      focus_r       <= '0;
      axial_len_r   <= '0;
      pbc_r         <= '0;
    end else if (cfg_we) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_BOX_L:       box_l_r       <= cfg_wdata[8:0];
        CFG_BOX_M:       box_m_r       <= cfg_wdata[8:0];
        CFG_PSF_LATERAL: psf_lateral_r <= cfg_wdata[5:0];
        CFG_PSF_AXIAL:   psf_axial_r   <= cfg_wdata[6:0];
        CFG_FOCUS:       focus_r       <= cfg_wdata;
        CFG_AXIAL_LEN:   axial_len_r   <= cfg_wdata;
        CFG_PBC_MASK:    pbc_r         <= cfg_wdata[2:0];
        default: ;
      endcase
    end
  end

  // Clamped extents and box margins
  logic [8:0]     bl, bm;
  logic [5:0]     lp;
  logic [6:0]     ap;
  logic [FLW:0]   mx_full;
  logic [FMW:0]   my_full;
  logic [FLW-1:0] mx;
  logic [FMW-1:0] my;

  assign bl = (11'(box_l_r) > 11'(FRAME_L)) ? 9'(FRAME_L) : box_l_r;
  assign bm = (11'(box_m_r) > 11'(FRAME_M)) ? 9'(FRAME_M) : box_m_r;
  assign lp = (9'(psf_lateral_r) > 9'(PSF_LATERAL_MAX)) ? 6'(PSF_LATERAL_MAX) : psf_lateral_r;
  assign ap = (9'(psf_axial_r) > 9'(PSF_AXIAL_MAX)) ? 7'(PSF_AXIAL_MAX) : psf_axial_r;
  assign mx_full = (FLW+1)'(FRAME_L) - (FLW+1)'(bl);
  assign my_full = (FMW+1)'(FRAME_M) - (FMW+1)'(bm);
  assign mx = FLW'(mx_full >> 1);
  assign my = FMW'(my_full >> 1);

  // State
  state_t          state_r, state_nxt;
  in_item_t        item_r, item_nxt;
  logic [CLRW-1:0] clr_r, clr_nxt;
  logic [SW-1:0]   acc_r, acc_nxt;
  logic [3:0]      sh_r, sh_nxt;
  logic            sel_r, sel_nxt;
  logic [SW-1:0]   rv_r, rv_nxt, cv_r, cv_nxt, cstart_r, cstart_nxt;
  logic [6:0]      i_r, i_nxt, j_r, j_nxt;
  logic [KW-1:0]   k_r, k_nxt;
  logic            p1_valid_r, p1_valid_nxt;
  logic [IAW-1:0]  p1_addr_r;
  logic            fwd_r, fwd_nxt;
  logic [31:0]     fwd_data_r;
  logic            rd_hit_r, rd_hit_nxt;
  logic [31:0]     res_pix_r, res_pix_nxt;
  logic            out_valid_r, out_valid_nxt;
  out_item_t       out_data_r, out_data_nxt;

  // Memory ports
  logic           psf_we, img_we;
  logic [PAW-1:0] psf_waddr, psf_raddr;
  logic [IAW-1:0] img_waddr, img_raddr;
  logic [15:0]    psf_wdata, psf_rdata;
  logic [31:0]    img_wdata, img_rdata;

  psu_ram #(.W(16), .DEPTH(PSF_DEPTH)) u_psf_ram (
    .clk(clk), .we(psf_we), .waddr(psf_waddr), .wdata(psf_wdata),
    .raddr(psf_raddr), .rdata(psf_rdata)
  );

  psu_ram #(.W(32), .DEPTH(IMG_DEPTH)) u_img_ram (
    .clk(clk), .we(img_we), .waddr(img_waddr), .wdata(img_wdata),
    .raddr(img_raddr), .rdata(img_rdata)
  );

  // Item decode
  logic chok, ld_ok, wrap_l, wrap_m;
  assign chok   = 4'(item_r.channel) < 4'(CHANNELS);
  assign ld_ok  = chok && (item_r.row_index < {2'b0, lp}) &&
                  (item_r.column_index < {2'b0, lp}) && ({1'b0, item_r.depth_index} < ap);
  assign wrap_l = pbc_r[0];
  assign wrap_m = pbc_r[1];

  // Rounded positions, signed window starts, axial depth
  logic [XW-1:0] xl, xm;
  logic [SW-1:0] sl, sm;
  logic [19:0]   d0, d1;
  logic [11:0]   kd;
  logic          splat_ok;
  assign xl = XW'(item_r.pos_l[19:8]) + ((item_r.pos_l[7:0] > 8'd128) ? XW'(1) : XW'(0));
  assign xm = XW'(item_r.pos_m[19:8]) + ((item_r.pos_m[7:0] > 8'd128) ? XW'(1) : XW'(0));
  assign sl = {1'b0, xl} - SW'(lp) + SW'(1);
  assign sm = {1'b0, xm} - SW'(lp) + SW'(1);
  assign d0 = (item_r.pos_n >= focus_r) ? item_r.pos_n - focus_r : focus_r - item_r.pos_n;
  assign d1 = (pbc_r[2] && ({d0, 1'b0} > {1'b0, axial_len_r})) ?
              ((d0 >= axial_len_r) ? d0 - axial_len_r : axial_len_r - d0) : d0;
  assign kd = d1[19:8];
  assign splat_ok = {kd, 1'b0} < 13'(ap);

  // Shared modulo step: add box while negative, else restoring subtract
  logic [8:0]    mod_n;
  logic [20:0]   mod_sh;
  logic [SW-1:0] mod_acc;
  logic          mod_done;
  assign mod_n  = sel_r ? bm : bl;
  assign mod_sh = 21'(mod_n) << sh_r;
  always_comb begin
    mod_acc  = acc_r;
    mod_done = 1'b0;
    if (acc_r[SW-1]) begin
      mod_acc = acc_r + SW'(mod_n);
    end else begin
      if (21'(acc_r) >= mod_sh) begin
        mod_acc = acc_r - SW'(mod_sh);
      end
      mod_done = (sh_r == 4'd0);
    end
  end

  // Walk pixel checks and addresses
  logic [6:0]    lim_m1, i_abs, j_abs;
  logic          row_ok, col_ok, pix_ok, j_last, i_last;
  logic [SW-1:0] rv_step, cv_step;
  logic [IAW-1:0] walk_addr, rd_addr;
  logic [PAW-1:0] walk_psf_addr;
  logic          rd_inside;
  assign lim_m1 = {1'b0, lp} - 7'd1;
  assign i_abs  = i_r[6] ? 7'(-i_r) : i_r;
  assign j_abs  = j_r[6] ? 7'(-j_r) : j_r;
  assign row_ok = wrap_l || (!rv_r[SW-1] && (rv_r[SW-2:0] < XW'(bl)));
  assign col_ok = wrap_m || (!cv_r[SW-1] && (cv_r[SW-2:0] < XW'(bm)));
  assign pix_ok = row_ok && col_ok;
  assign j_last = (j_r == lim_m1);
  assign i_last = (i_r == lim_m1);
  assign rv_step = (wrap_l && (rv_r + SW'(1) == SW'(bl))) ? '0 : rv_r + SW'(1);
  assign cv_step = (wrap_m && (cv_r + SW'(1) == SW'(bm))) ? '0 : cv_r + SW'(1);
  assign walk_addr = IAW'(32'(item_r.channel) * IMG_CH +
                          (32'(rv_r[8:0]) + 32'(mx)) * FRAME_M +
                          32'(cv_r[8:0]) + 32'(my));
  assign walk_psf_addr = PAW'(32'(item_r.channel) * PSF_CH +
                              32'(LW'(i_abs)) * PSF_ROW +
                              32'(LW'(j_abs)) * PSF_AXIAL_MAX + 32'(k_r));
  assign rd_inside = (12'(item_r.row_index) >= 12'(mx)) &&
                     (12'(item_r.row_index) < 12'(mx) + 12'(bl)) &&
                     (12'(item_r.column_index) >= 12'(my)) &&
                     (12'(item_r.column_index) < 12'(my) + 12'(bm)) &&
                     (12'(item_r.row_index) < 12'(FRAME_L)) &&
                     (12'(item_r.column_index) < 12'(FRAME_M));
  assign rd_addr = IAW'(32'(item_r.channel) * IMG_CH +
                        32'(item_r.row_index) * FRAME_M + 32'(item_r.column_index));

  // Saturating pixel update with forward of the previous write
  logic [31:0] upd_base, upd_data;
  logic [32:0] upd_sum;
  assign upd_base = fwd_r ? fwd_data_r : img_rdata;
  assign upd_sum  = {1'b0, upd_base} + 33'(psf_rdata);
  assign upd_data = upd_sum[32] ? '1 : upd_sum[31:0];

  // Memory port selection
  always_comb begin
    psf_we    = 1'b0;
    psf_waddr = PAW'(clr_r);
    psf_wdata = '0;
    img_we    = 1'b0;
    img_waddr = IAW'(clr_r);
    img_wdata = '0;
    psf_raddr = walk_psf_addr;
    img_raddr = (state_r == ST_WALK) ? walk_addr : rd_addr;
    if (state_r == ST_CLEAR) begin
      psf_we = (clr_r < CLRW'(PSF_DEPTH));
      img_we = (clr_r < CLRW'(IMG_DEPTH));
    end else begin
      if ((state_r == ST_LOAD_A || state_r == ST_LOAD_B) && ld_ok) begin
        psf_we    = 1'b1;
        psf_wdata = item_r.psf_value;
        psf_waddr = (state_r == ST_LOAD_A) ?
          PAW'(32'(item_r.channel) * PSF_CH + 32'(LW'(item_r.row_index)) * PSF_ROW +
               32'(LW'(item_r.column_index)) * PSF_AXIAL_MAX + 32'(KW'(item_r.depth_index))) :
          PAW'(32'(item_r.channel) * PSF_CH + 32'(LW'(item_r.column_index)) * PSF_ROW +
               32'(LW'(item_r.row_index)) * PSF_AXIAL_MAX + 32'(KW'(item_r.depth_index)));
      end
      if (p1_valid_r) begin
        img_we    = 1'b1;
        img_waddr = p1_addr_r;
        img_wdata = upd_data;
      end else if (state_r == ST_RD_WAIT && rd_hit_r) begin
        img_we    = 1'b1;
        img_waddr = rd_addr;
      end
    end
  end

  // Sequencer: next state and datapath registers
  always_comb begin
    state_nxt    = state_r;
    item_nxt     = item_r;
    clr_nxt      = clr_r;
    acc_nxt      = acc_r;
    sh_nxt       = sh_r;
    sel_nxt      = sel_r;
    rv_nxt       = rv_r;
    cv_nxt       = cv_r;
    cstart_nxt   = cstart_r;
    i_nxt        = i_r;
    j_nxt        = j_r;
    k_nxt        = k_r;
    p1_valid_nxt = 1'b0;
    fwd_nxt      = 1'b0;
    rd_hit_nxt   = rd_hit_r;
    res_pix_nxt  = res_pix_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_data_nxt = out_data_r;
    unique case (state_r)
      ST_CLEAR: begin
        clr_nxt = clr_r + CLRW'(1);
        if (clr_r == CLRW'(CLR_DEPTH - 1)) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_valid) begin
          item_nxt = in_data;
          unique case (in_data.operation)
            OP_LOAD:  state_nxt = ST_LOAD_A;
            OP_SPLAT: state_nxt = ST_SETUP;
            OP_READ:  state_nxt = ST_RD_ISSUE;
            default:  state_nxt = ST_IDLE;
          endcase
        end
      end
      ST_LOAD_A: state_nxt = ST_LOAD_B;
      ST_LOAD_B: state_nxt = ST_IDLE;
      ST_SETUP: begin
        if (!chok || !splat_ok || lp == 6'd0 || bl == 9'd0 || bm == 9'd0) begin
          state_nxt = ST_IDLE;
        end else begin
          rv_nxt     = sl;
          cstart_nxt = sm;
          cv_nxt     = sm;
          i_nxt      = 7'd0 - lim_m1;
          j_nxt      = 7'd0 - lim_m1;
          k_nxt      = KW'(kd);
          sh_nxt     = 4'(MOD_TOP);
          if (wrap_l) begin
            acc_nxt   = sl;
            sel_nxt   = 1'b0;
            state_nxt = ST_MOD;
          end else if (wrap_m) begin
            acc_nxt   = sm;
            sel_nxt   = 1'b1;
            state_nxt = ST_MOD;
          end else begin
            state_nxt = ST_WALK;
          end
        end
      end
      ST_MOD: begin
        acc_nxt = mod_acc;
        if (!acc_r[SW-1] && !mod_done) begin
          sh_nxt = sh_r - 4'd1;
        end
        if (mod_done) begin
          if (!sel_r) begin
            rv_nxt = mod_acc;
            if (wrap_m) begin
              acc_nxt = cstart_r;
              sel_nxt = 1'b1;
              sh_nxt  = 4'(MOD_TOP);
            end else begin
              state_nxt = ST_WALK;
            end
          end else begin
            cstart_nxt = mod_acc;
            cv_nxt     = mod_acc;
            state_nxt  = ST_WALK;
          end
        end
      end
      ST_WALK: begin
        p1_valid_nxt = pix_ok;
        fwd_nxt      = pix_ok && p1_valid_r && (walk_addr == p1_addr_r);
        if (j_last) begin
          j_nxt  = 7'd0 - lim_m1;
          cv_nxt = cstart_r;
          if (i_last) begin
            state_nxt = ST_DRAIN;
          end else begin
            i_nxt  = i_r + 7'd1;
            rv_nxt = rv_step;
          end
        end else begin
          j_nxt  = j_r + 7'd1;
          cv_nxt = cv_step;
        end
      end
      ST_DRAIN: state_nxt = ST_IDLE;
      ST_RD_ISSUE: begin
        rd_hit_nxt = rd_inside && chok;
        state_nxt  = ST_RD_WAIT;
      end
      ST_RD_WAIT: begin
        res_pix_nxt = rd_hit_r ? img_rdata : '0;
        state_nxt   = ST_RD_DONE;
      end
      ST_RD_DONE: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = '{pixel_value: res_pix_r, outside_box: !rd_inside};
          state_nxt     = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      clr_r       <= '0;
      p1_valid_r  <= 1'b0;
      fwd_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_r       <= clr_nxt;
      p1_valid_r  <= p1_valid_nxt;
      fwd_r       <= fwd_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    item_r     <= item_nxt;
    acc_r      <= acc_nxt;
    sh_r       <= sh_nxt;
    sel_r      <= sel_nxt;
    rv_r       <= rv_nxt;
    cv_r       <= cv_nxt;
    cstart_r   <= cstart_nxt;
    i_r        <= i_nxt;
    j_r        <= j_nxt;
    k_r        <= k_nxt;
    p1_addr_r  <= walk_addr;
    fwd_data_r <= upd_data;
    rd_hit_r   <= rd_hit_nxt;
    res_pix_r  <= res_pix_nxt;
    out_data_r <= out_data_nxt;
  end

  assign in_stall  = (state_r != ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // Forwarding only while a pixel write is in flight
  `PSU_ASSERT(a_fwd_with_write, fwd_r |-> p1_valid_r)
  // Pixel writes only trail the walk
  `PSU_ASSERT(a_write_after_walk, p1_valid_r |-> (state_r == ST_WALK || state_r == ST_DRAIN))
  // A new result only comes out of a finished read
  `PSU_ASSERT(a_result_from_read, $rose(out_valid_r) |-> $past(state_r) == ST_RD_DONE)
  // Wrapped row coordinate stays inside the box during the walk
  `PSU_NEVER(a_row_in_box, state_r == ST_WALK && wrap_l && (rv_r[SW-1] || rv_r >= SW'(bl)))

endmodule

FILE: sim/psf_splat_accumulator_unit_test.sv
// Self-checking testbench for the PSF splat accumulator unit.
`timescale 1ns / 1ps

module psf_splat_accumulator_unit_test;
  import psu_pkg::*;

  localparam int N_CH   = CHANNELS_DEF;
  localparam int LAT_MX = PSF_LATERAL_MAX_DEF;
  localparam int AX_MX  = PSF_AXIAL_MAX_DEF;
  localparam int FR_L   = FRAME_L_DEF;
  localparam int FR_M   = FRAME_M_DEF;
  // longest splat walk plus modulo steps and drain, with margin
  localparam int SETTLE = 5000;

  // Golden image and PSF store, register copy and queue of pending pixel reads
  class splat_scoreboard;
    bit [15:0] psf_mem [N_CH*LAT_MX*LAT_MX*AX_MX];
    bit [31:0] img_mem [N_CH*FR_L*FR_M];
    int unsigned box_l = 256, box_m = 256, lat = 32, ax = 64;
    int unsigned focus = 0, alen = 0, pbc = 0;
    out_item_t pixel_q[$];
    int errors = 0;

    function int unsigned clampv(int unsigned v, int unsigned hi);
      return v > hi ? hi : v;
    endfunction

    function int place(int v, int n, bit wrap);
      int r;
      if (n <= 0) return -1;
      if (wrap) begin
        r = v % n;
        if (r < 0) r += n;
        return r;
      end
      return (v >= 0 && v < n) ? v : -1;
    endfunction

    function int unsigned round_pos(bit [19:0] p);
      return (p >> 8) + ((p[7:0] > 8'd128) ? 1 : 0);
    endfunction

    function void write_reg(cfg_idx_t idx, int unsigned v);
      case (idx)
        CFG_BOX_L:       box_l = v & 'h1FF;
        CFG_BOX_M:       box_m = v & 'h1FF;
        CFG_PSF_LATERAL: lat   = v & 'h3F;
        CFG_PSF_AXIAL:   ax    = v & 'h7F;
        CFG_FOCUS:       focus = v & 'hFFFFF;
        CFG_AXIAL_LEN:   alen  = v & 'hFFFFF;
        CFG_PBC_MASK:    pbc   = v & 7;
        default: ;
      endcase
    endfunction

    // Apply one accepted beat to the golden state
    function void note_input(in_item_t it);
      int unsigned bl, bm, lp, ap, mx, my, ch, d, k, xl, xm, v;
      int r, c, ad;
      bit in_box;
      out_item_t e;
      bl = clampv(box_l, FR_L);
      bm = clampv(box_m, FR_M);
      lp = clampv(lat, LAT_MX);
      ap = clampv(ax, AX_MX);
      mx = (FR_L - bl) / 2;
      my = (FR_M - bm) / 2;
      ch = it.channel;
      case (it.operation)
        OP_LOAD: begin
          if (ch < N_CH && it.row_index < lp && it.column_index < lp && it.depth_index < ap) begin
            psf_mem[((ch*LAT_MX + it.row_index)*LAT_MX + it.column_index)*AX_MX
                    + it.depth_index] = it.psf_value;
            psf_mem[((ch*LAT_MX + it.column_index)*LAT_MX + it.row_index)*AX_MX
                    + it.depth_index] = it.psf_value;
          end
        end
        OP_SPLAT: begin
          if (ch < N_CH) begin
            xl = round_pos(it.pos_l);
            xm = round_pos(it.pos_m);
            d = it.pos_n >= focus ? it.pos_n - focus : focus - it.pos_n;
            if (pbc[2] && 2*d > alen) d = d >= alen ? d - alen : alen - d;
            k = d >> 8;
            if (2*k < ap) begin
              for (int i = 1 - int'(lp); i < int'(lp); i++) begin
                r = place(int'(xl) + i, bl, pbc[0]);
                if (r < 0) continue;
                for (int j = 1 - int'(lp); j < int'(lp); j++) begin
                  c = place(int'(xm) + j, bm, pbc[1]);
                  if (c < 0) continue;
                  ad = (ch*FR_L + r + mx)*FR_M + c + my;
                  v = psf_mem[((ch*LAT_MX + (i < 0 ? -i : i))*LAT_MX + (j < 0 ? -j : j))
                              *AX_MX + k];
                  img_mem[ad] = (img_mem[ad] + v < img_mem[ad]) ? 32'hFFFF_FFFF
                                                              : img_mem[ad] + v;
                end
              end
            end
          end
        end
        OP_READ: begin
          in_box = it.row_index >= mx && it.row_index < mx + bl && it.column_index >= my
                   && it.column_index < my + bm;
          e.pixel_value = 0;
          if (in_box && ch < N_CH) begin
            ad = (ch*FR_L + it.row_index)*FR_M + it.column_index;
            e.pixel_value = img_mem[ad];
            img_mem[ad] = 0;
          end
          e.outside_box = !in_box;
          pixel_q.push_back(e);
        end
        default: ;
      endcase
    endfunction

    // Compare a result beat with the oldest pending read
    function void check_result(out_item_t got);
      out_item_t e;
      if (pixel_q.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual %h/%0b", $time,
                 got.pixel_value, got.outside_box);
        errors++;
        return;
      end
      e = pixel_q.pop_front();
      if (got.pixel_value !== e.pixel_value) begin
        $display("%0t: pixel_value mismatch, expected %h, actual %h", $time,
                 e.pixel_value, got.pixel_value);
        errors++;
      end
      if (got.outside_box !== e.outside_box) begin
        $display("%0t: outside_box mismatch, expected %0b, actual %0b", $time,
                 e.outside_box, got.outside_box);
        errors++;
      end
    endfunction
  endclass

  logic clk = 0, rst_n = 0;
  logic in_valid = 0, in_stall, out_valid, out_stall = 0;
  in_item_t in_data = '0;
  out_item_t out_data;
  logic cfg_we = 0;
  logic [CFG_IW-1:0] cfg_index = '0;
  logic [CFG_DW-1:0] cfg_wdata = '0;

  splat_scoreboard sb = new();
  int send_pct = 0, recv_pct = 0;
  int hold_left = 0;
  bit hold_req = 0;
  int unsigned last_row = 0, last_col = 0;

  psf_splat_accumulator_unit uut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
  );

  always begin
    #4 clk = 1;
    #4 clk = 0;
  end

  // Drive result back-pressure, with an occasional long hold-off
  always @(negedge clk) begin
    if (hold_req) begin
      hold_left = 400;
      hold_req = 0;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1;
    end else begin
      out_stall <= ($urandom_range(99) < recv_pct);
    end
  end

  // Check each accepted result beat
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) sb.check_result(out_data);
  end

  initial begin
    #50_000_000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  // Offer one beat and hold it until accepted; called and returning at a falling edge
  task automatic send_beat(in_item_t it);
    while ($urandom_range(99) < send_pct) begin
      in_valid <= 0;
      @(negedge clk);
    end
    in_valid <= 1;
    in_data <= it;
    forever begin
      @(posedge clk);
      if (!in_stall) break;
    end
    sb.note_input(it);
    @(negedge clk);
  endtask

  // Wait for every pending read, then let a splat walk finish
  task automatic drain_and_settle();
    in_valid <= 0;
    while (sb.pixel_q.size() > 0) @(negedge clk);
    repeat (SETTLE) @(negedge clk);
  endtask

  task automatic set_regs(int unsigned bl, bm, lp, ap, fp, len, pm);
    int unsigned vals [7];
    vals = '{bl, bm, lp, ap, fp, len, pm};
    for (int i = 0; i < 7; i++) begin
      cfg_we <= 1;
      cfg_index <= cfg_idx_t'(i);
      cfg_wdata <= CFG_DW'(vals[i]);
      sb.write_reg(cfg_idx_t'(i), vals[i]);
      @(negedge clk);
    end
    cfg_we <= 0;
  endtask

  function automatic in_item_t mk(op_t op, int unsigned ch, pl, pm, pn, row, col, dep, val);
    in_item_t it;
    it.operation = op;
    it.channel = 2'(ch);
    it.pos_l = 20'(pl);
    it.pos_m = 20'(pm);
    it.pos_n = 20'(pn);
    it.row_index = 8'(row);
    it.column_index = 8'(col);
    it.depth_index = 6'(dep);
    it.psf_value = 16'(val);
    return it;
  endfunction

  // Random beat shaped by the current register setting
  function automatic in_item_t rand_beat();
    in_item_t it;
    int unsigned sel, bl, bm, lp, ap, mx, my;
    bl = sb.clampv(sb.box_l, FR_L);
    bm = sb.clampv(sb.box_m, FR_M);
    lp = sb.clampv(sb.lat, LAT_MX);
    ap = sb.clampv(sb.ax, AX_MX);
    mx = (FR_L - bl) / 2;
    my = (FR_M - bm) / 2;
    it = in_item_t'($bits(in_item_t)'({$urandom, $urandom, $urandom, $urandom}));
    sel = $urandom_range(99);
    if (sel < 35) begin
      it.operation = OP_LOAD;
      if ($urandom_range(9) < 8) begin
        it.row_index = 8'($urandom_range(lp));
        it.column_index = 8'($urandom_range(lp));
        it.depth_index = 6'($urandom_range(ap > 0 ? ap - 1 : 0));
      end
    end else if (sel < 60) begin
      it.operation = OP_SPLAT;
      if ($urandom_range(9) < 8) begin
        it.pos_l = 20'(($urandom_range(bl + 4) << 8) | $urandom_range(255));
        it.pos_m = 20'(($urandom_range(bm + 4) << 8) | $urandom_range(255));
        it.pos_n = 20'(sb.focus + $urandom_range(ap * 128) - $urandom_range(ap * 128));
        last_row = mx + (it.pos_l >> 8);
        last_col = my + (it.pos_m >> 8);
      end
    end else if (sel < 95) begin
      it.operation = OP_READ;
      if ($urandom_range(9) < 7) begin
        it.row_index = 8'(last_row + $urandom_range(4) - 2);
        it.column_index = 8'(last_col + $urandom_range(4) - 2);
      end
    end else begin
      it.operation = OP_NONE;
    end
    return it;
  endfunction

  initial begin
    in_item_t dir [$];
    rst_n = 0;
    repeat (10) @(negedge clk);
    rst_n = 1;
    // hold off until the clearing pass is done
    forever begin
      @(posedge clk);
      if (!in_stall) break;
    end
    @(negedge clk);

    // Directed: box 20x17 starting at (118,119), P=4, A=8, all wraps on
    send_pct = 13; recv_pct = 83;
    set_regs(20, 17, 4, 8, 'h1000, 'h3000, 7);
    dir.push_back(mk(OP_LOAD, 0, 0, 0, 0, 0, 0, 0, 'hFFFF));
    dir.push_back(mk(OP_LOAD, 0, 0, 0, 0, 3, 1, 7, 'h8000));
    dir.push_back(mk(OP_LOAD, 0, 0, 0, 0, 2, 3, 1, 'h1234));
    dir.push_back(mk(OP_LOAD, 0, 0, 0, 0, 1, 0, 0, 'h0001));
    dir.push_back(mk(OP_LOAD, 3, 0, 0, 0, 4, 0, 0, 'hAAAA));   // past lateral extent
    dir.push_back(mk(OP_LOAD, 3, 0, 0, 0, 0, 0, 8, 'h5555));   // past axial extent
    dir.push_back(mk(OP_LOAD, 3, 0, 0, 0, 255, 255, 63, 'hFFFF));
    dir.push_back(mk(OP_NONE, 1, 'hFFFFF, 'hFFFFF, 'hFFFFF, 255, 255, 63, 'hFFFF));
    dir.push_back(mk(OP_SPLAT, 0, 'h580, 'h381, 'h1000, 0, 0, 0, 0));  // tie rounds down
    dir.push_back(mk(OP_READ, 0, 0, 0, 0, 123, 123, 0, 0));
    dir.push_back(mk(OP_READ, 0, 0, 0, 0, 123, 124, 0, 0));
    dir.push_back(mk(OP_SPLAT, 0, 'h13FF, 0, 'h3F00, 0, 0, 0, 0));   // lateral wrap, axial fold
    dir.push_back(mk(OP_READ, 0, 0, 0, 0, 118, 119, 0, 0));
    dir.push_back(mk(OP_READ, 0, 0, 0, 0, 137, 135, 0, 0));
    dir.push_back(mk(OP_SPLAT, 0, 'h500, 'h500, 'h2000, 0, 0, 0, 0));  // too deep, no splat
    dir.push_back(mk(OP_SPLAT, 2, 'hFFFFF, 'hFFFFF, 'hFFFFF, 0, 0, 0, 0));
    dir.push_back(mk(OP_READ, 0, 0, 0, 0, 123, 124, 0, 0));
    dir.push_back(mk(OP_READ, 0, 0, 0, 0, 0, 0, 0, 0));          // border
    dir.push_back(mk(OP_READ, 3, 0, 0, 0, 255, 255, 0, 0));
    dir.push_back(mk(OP_READ, 0, 0, 0, 0, 117, 119, 0, 0));
    dir.push_back(mk(OP_READ, 0, 0, 0, 0, 138, 136, 0, 0));
    foreach (dir[i]) send_beat(dir[i]);
    drain_and_settle();

    // Random phases over several register settings
    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0: set_regs(256, 256, 32, 64, 0, 0, 0);
        1: set_regs(1, 1, 3, 1, 'hFFFFF, 'hFFFFF, 3);
        2: set_regs(0, 0, 2, 2, 'h800, 'h400, 4);
        3: set_regs(300, 5, 63, 127, 'h4000, 'h2000, 2);
        4: set_regs(31, 200, 0, 5, 'h100, 'hFFFFF, 1);
        default: set_regs(64, 64, 5, 64, 'h2000, 'h1000, 6);
      endcase
      if (ph < 2) begin
        send_pct = 13; recv_pct = 83;
      end else if (ph < 4) begin
        send_pct = 83; recv_pct = 13;
      end else begin
        send_pct = 0; recv_pct = 0;
      end
      if (ph == 5) begin
        // hold results back while reads keep coming, so the input stalls
        hold_req = 1;
        for (int i = 0; i < 8; i++) send_beat(mk(OP_READ, i % 4, 0, 0, 0, 100 + i, 90, 0, 0));
      end
      for (int i = 0; i < 20; i++) send_beat(rand_beat());
      drain_and_settle();
    end

    if (sb.errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
